// ----- rtl/qlu_pkg.sv -----
// ----------------------------------------------------------------------------
// qlu_pkg
// shared types, codes and constants of the quoted line unescaper
// ----------------------------------------------------------------------------
package qlu_pkg;

    localparam int LINE_LIMIT_DEF = 100;
    localparam int MAX_RESULTS    = 3;
    localparam int QUEUE_DEPTH    = 4;
    localparam int LEN_W          = 7;
    localparam int SLOT_W         = 2;

    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_BS    = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;

    typedef enum logic [1:0] {
        KIND_LINE = 2'd0,
        KIND_STR  = 2'd1,
        KIND_SEP  = 2'd2,
        KIND_EOL  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MODE_LINE     = 2'd0,
        MODE_STR      = 2'd1,
        MODE_AFTER_NL = 2'd2,
        MODE_AFTER_BS = 2'd3
    } t_mode;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
    } t_slot;

    // results caused by one byte, end of line always in the last used slot
    typedef struct packed {
        t_slot [MAX_RESULTS-1:0] slot;
        logic [SLOT_W-1:0]       cnt;
        logic [LEN_W-1:0]        len;
        logic                    open_str;
    } t_plan;

endpackage

// ----- rtl/quoted_line_unescaper.sv -----
// ----------------------------------------------------------------------------
// quoted_line_unescaper
// line splitter and double-quoted string unescaper for a byte stream
// ----------------------------------------------------------------------------
// Takes one byte item per clock and turns it into zero to three result items:
// line characters (the first LINE_LIMIT of each line), unescaped string bytes,
// a NUL separator ahead of each string that follows a non-empty string on the
// same line, and an end-of-line item with the stored line length at a newline
// outside a string or at the end of the file (open_string set when the file
// ends inside a string). Input bytes are taken one per cycle as long as the
// four-entry queue between front and back has room; results leave one per
// cycle through the output register while the result side does not stall, so
// the sustained rate is one byte per cycle for bytes that give one result or
// none, and bytes that give two or three results send them out one by one.
// An accepted byte's results pass through the queue, then the output register.
// ----------------------------------------------------------------------------
module quoted_line_unescaper #(
    parameter int LINE_LIMIT = qlu_pkg::LINE_LIMIT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // byte channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_byte_in,
    input  logic                      i_end_of_file,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [1:0]                o_kind,
    output logic [7:0]                o_value,
    output logic [qlu_pkg::LEN_W-1:0] o_line_length,
    output logic                      o_open_string,
    output logic                      o_last
);
    import qlu_pkg::*;

    logic  s_accept;
    logic  s_push, s_full, s_pop, s_q_valid;
    t_plan s_plan, s_q_plan;

    // a byte is taken whenever the queue has a free entry
    assign o_stall  = s_full;
    assign s_accept = i_valid && !s_full;

    // front: mode, line count and separator state, builds the result list
    qlu_front #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (s_accept),
        .i_byte_in     (i_byte_in),
        .i_end_of_file (i_end_of_file),
        .o_push        (s_push),
        .o_plan        (s_plan)
    );

    // decouples byte intake from result delivery
    qlu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_plan  (s_plan),
        .i_pop   (s_pop),
        .o_full  (s_full),
        .o_valid (s_q_valid),
        .o_plan  (s_q_plan)
    );

    // back: one result item per cycle into the output register while not stalled
    qlu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (s_q_valid),
        .i_q_plan      (s_q_plan),
        .o_pop         (s_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_value       (o_value),
        .o_line_length (o_line_length),
        .o_open_string (o_open_string),
        .o_last        (o_last)
    );

endmodule

// ----- rtl/qlu_front.sv -----
// ----------------------------------------------------------------------------
// qlu_front
// classifies each byte, keeps the line state, builds the list of results
// ----------------------------------------------------------------------------
module qlu_front #(
    parameter int LINE_LIMIT = qlu_pkg::LINE_LIMIT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte_in,
    input  logic           i_end_of_file,
    output logic           o_push,
    output qlu_pkg::t_plan o_plan
);
    import qlu_pkg::*;

    localparam logic [LEN_W-1:0] LimW = LEN_W'(LINE_LIMIT);

    t_mode            r_mode, n_mode, s_mode_mid;
    logic [LEN_W-1:0] r_count, n_count, s_count_mid;
    logic             r_nonempty, n_nonempty;
    logic             s_line_ended;
    logic             s_below;

    assign s_below = (r_count < LimW);

    // next state
    always_comb begin
        s_mode_mid   = r_mode;
        s_count_mid  = r_count;
        n_nonempty   = r_nonempty;
        s_line_ended = 1'b0;
        unique case (r_mode)
            MODE_LINE: begin
                if (i_byte_in == CHAR_NL) begin
                    s_count_mid  = '0;
                    n_nonempty   = 1'b0;
                    s_line_ended = 1'b1;
                end else begin
                    if (s_below) s_count_mid = r_count + 1'b1;
                    if (i_byte_in == CHAR_QUOTE) s_mode_mid = MODE_STR;
                end
            end
            MODE_AFTER_BS: begin
                n_nonempty = 1'b1;
                s_mode_mid = MODE_STR;
            end
            default: begin
                if (r_mode == MODE_AFTER_NL && i_byte_in == CHAR_TAB) begin
                    s_mode_mid = MODE_STR;
                end else if (i_byte_in == CHAR_QUOTE) begin
                    s_mode_mid = MODE_LINE;
                end else if (i_byte_in == CHAR_BS) begin
                    s_mode_mid = MODE_AFTER_BS;
                end else begin
                    n_nonempty = 1'b1;
                    s_mode_mid = (i_byte_in == CHAR_NL) ? MODE_AFTER_NL : MODE_STR;
                end
            end
        endcase
        n_mode  = s_mode_mid;
        n_count = s_count_mid;
        if (i_end_of_file) begin
            n_mode     = MODE_LINE;
            n_count    = '0;
            n_nonempty = 1'b0;
        end
    end

    // result list
    always_comb begin
        o_plan = '0;
        unique case (r_mode)
            MODE_LINE: begin
                if (i_byte_in == CHAR_NL) begin
                    o_plan.slot[o_plan.cnt] = '{kind: KIND_EOL, value: 8'd0};
                    o_plan.cnt = o_plan.cnt + 1'b1;
                end else begin
                    if (s_below) begin
                        o_plan.slot[o_plan.cnt] = '{kind: KIND_LINE, value: i_byte_in};
                        o_plan.cnt = o_plan.cnt + 1'b1;
                    end
                    if (i_byte_in == CHAR_QUOTE && r_nonempty) begin
                        o_plan.slot[o_plan.cnt] = '{kind: KIND_SEP, value: 8'd0};
                        o_plan.cnt = o_plan.cnt + 1'b1;
                    end
                end
            end
            MODE_AFTER_BS: begin
                o_plan.slot[o_plan.cnt] = '{kind: KIND_STR, value: i_byte_in};
                o_plan.cnt = o_plan.cnt + 1'b1;
            end
            default: begin
                if (!(r_mode == MODE_AFTER_NL && i_byte_in == CHAR_TAB) &&
                    i_byte_in != CHAR_QUOTE && i_byte_in != CHAR_BS) begin
                    o_plan.slot[o_plan.cnt] = '{kind: KIND_STR, value: i_byte_in};
                    o_plan.cnt = o_plan.cnt + 1'b1;
                end
            end
        endcase
        if (i_end_of_file) begin
            if (s_mode_mid == MODE_AFTER_BS) begin
                o_plan.slot[o_plan.cnt] = '{kind: KIND_STR, value: CHAR_BS};
                o_plan.cnt = o_plan.cnt + 1'b1;
            end
            if (!s_line_ended) begin
                o_plan.slot[o_plan.cnt] = '{kind: KIND_EOL, value: 8'd0};
                o_plan.cnt      = o_plan.cnt + 1'b1;
                o_plan.open_str = (s_mode_mid != MODE_LINE);
            end
        end
        o_plan.len = s_line_ended ? r_count : s_count_mid;
        o_push     = i_accept && (o_plan.cnt != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_LINE;
            r_count    <= '0;
            r_nonempty <= 1'b0;
        end else if (i_accept) begin
            r_mode     <= n_mode;
            r_count    <= n_count;
            r_nonempty <= n_nonempty;
        end
    end

endmodule

// ----- rtl/qlu_queue.sv -----
// ----------------------------------------------------------------------------
// qlu_queue
// short queue of result lists between front and back
// ----------------------------------------------------------------------------
module qlu_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  qlu_pkg::t_plan i_plan,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output qlu_pkg::t_plan o_plan
);
    import qlu_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_plan             r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0]   r_wr, r_rd;
    logic [CntW-1:0]   r_cnt;
    logic              s_push, s_pop;

    assign o_full  = (r_cnt == CntW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_plan  = r_mem[r_rd];
    assign s_push  = i_push && !o_full;
    assign s_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (s_push) r_mem[r_wr] <= i_plan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (s_push) r_wr <= r_wr + 1'b1;
            if (s_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + CntW'(s_push) - CntW'(s_pop);
        end
    end

endmodule

// ----- rtl/qlu_back.sv -----
// ----------------------------------------------------------------------------
// qlu_back
// walks the queued result lists and drives one result item per cycle unless stalled
// ----------------------------------------------------------------------------
module qlu_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  qlu_pkg::t_plan            i_q_plan,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [1:0]                o_kind,
    output logic [7:0]                o_value,
    output logic [qlu_pkg::LEN_W-1:0] o_line_length,
    output logic                      o_open_string,
    output logic                      o_last
);
    import qlu_pkg::*;

    logic [SLOT_W-1:0] r_idx;
    logic              r_valid;
    t_kind             r_kind;
    logic [7:0]        r_value;
    logic [LEN_W-1:0]  r_len;
    logic              r_open, r_last;
    logic              s_load, s_end;
    t_slot             s_slot;

    assign s_load = i_q_valid && (!r_valid || !i_stall);
    assign s_slot = i_q_plan.slot[r_idx];
    assign s_end  = (r_idx == i_q_plan.cnt - 1'b1);
    assign o_pop  = s_load && s_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (s_load) begin
                r_valid <= 1'b1;
                r_idx   <= s_end ? '0 : r_idx + 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_kind  <= s_slot.kind;
            r_value <= s_slot.value;
            r_len   <= (s_slot.kind == KIND_EOL) ? i_q_plan.len : '0;
            r_open  <= (s_slot.kind == KIND_EOL) && i_q_plan.open_str;
            r_last  <= s_end;
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_value       = r_value;
    assign o_line_length = r_len;
    assign o_open_string = r_open;
    assign o_last        = r_last;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the quoted line unescaper
// ----------------------------------------------------------------------------
// Feeds byte items through the valid/stall input channel and checks every
// result item against a typed-in result or an in-bench model of the line
// splitter and string unescaper. A short table of directed bytes comes
// first: after-reset and extreme bytes, escapes, newline-tab, separators and
// the end-of-file cases. Then random bursts follow, mostly well-formed lines
// with quoted strings of random content, plus long lines, noise and files
// cut off inside a string. Both channels idle at random, and once the result
// side holds off long enough for the block to fill up and stall its input.
// ----------------------------------------------------------------------------
module tb;

    import qlu_pkg::*;

    localparam int LIMIT        = LINE_LIMIT_DEF;
    localparam int N_ITEMS      = 320;
    localparam int N_DIRECTED   = 24;
    localparam int HOLD_CYCLES  = 80;

    // one byte item, with an optional typed-in single expected result
    typedef struct {
        logic [7:0]       data;
        logic             eof;
        bit               typed;
        t_kind            kind;
        logic [7:0]       value;
        logic [LEN_W-1:0] len;
        logic             open_str;
    } t_row;

    typedef struct {
        t_kind            kind;
        logic [7:0]       value;
        logic [LEN_W-1:0] len;
        logic             open_str;
        logic             last;
    } t_result;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_valid       = 1'b0;
    logic [7:0]       i_byte_in     = 8'h00;
    logic             i_end_of_file = 1'b0;
    logic             i_stall       = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [1:0]       o_kind;
    logic [7:0]       o_value;
    logic [LEN_W-1:0] o_line_length;
    logic             o_open_string;
    logic             o_last;

    // in-bench copy of the unescaper state
    t_mode            ub_mode     = MODE_LINE;
    logic [LEN_W-1:0] ub_len      = '0;
    bit               ub_nonempty = 1'b0;

    t_result fresh_results[$];    // results of the byte just accepted
    t_result pending_results[$];  // results still owed by the block
    t_row    burst_bytes[$];      // random burst being sent

    int failures     = 0;
    int n_checked    = 0;
    int n_sent       = 0;
    bit feed_quiet   = 1'b0;
    bit drain_quiet  = 1'b0;

    always #4 i_clk = ~i_clk;

    quoted_line_unescaper u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_byte_in     (i_byte_in),
        .i_end_of_file (i_end_of_file),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_value       (o_value),
        .o_line_length (o_line_length),
        .o_open_string (o_open_string),
        .o_last        (o_last)
    );

    // directed bytes; typed rows carry the one result that is obvious
    t_row directed_rows [N_DIRECTED] = '{
        // right after reset, and the byte extremes as line chars
        '{"a",        1'b0, 1'b1, KIND_LINE, "a",   7'd0, 1'b0},
        '{8'h00,      1'b0, 1'b1, KIND_LINE, 8'h00, 7'd0, 1'b0},
        '{8'hFF,      1'b0, 1'b1, KIND_LINE, 8'hFF, 7'd0, 1'b0},
        '{CHAR_NL,    1'b0, 1'b1, KIND_EOL,  8'h00, 7'd3, 1'b0},
        // string with an escaped quote and a newline-tab continuation
        '{CHAR_QUOTE, 1'b0, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        '{"x",        1'b0, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        '{CHAR_BS,    1'b0, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        '{CHAR_QUOTE, 1'b0, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        '{CHAR_NL,    1'b0, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        '{CHAR_TAB,   1'b0, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        '{CHAR_TAB,   1'b0, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        '{CHAR_QUOTE, 1'b0, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        // second string on the line gets a separator
        '{CHAR_QUOTE, 1'b0, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        '{"y",        1'b0, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        '{CHAR_QUOTE, 1'b0, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        '{CHAR_NL,    1'b0, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        // backslash as the last byte of the file
        '{CHAR_QUOTE, 1'b0, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        '{CHAR_BS,    1'b1, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        // quote as the last byte, with a separator due: three results
        '{CHAR_QUOTE, 1'b0, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        '{"z",        1'b0, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        '{CHAR_QUOTE, 1'b0, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        '{CHAR_QUOTE, 1'b1, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0},
        // newline at end of file: a single end of line, empty
        '{CHAR_NL,    1'b1, 1'b1, KIND_EOL,  8'h00, 7'd0, 1'b0},
        // plain char at end of file
        '{"q",        1'b1, 1'b0, KIND_LINE, 8'h00, 7'd0, 1'b0}
    };

    // mostly no idling, sometimes a few cycles, rarely a long stretch
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(12, 30);
    endfunction

    function automatic void add_result(t_kind k, logic [7:0] v, logic [LEN_W-1:0] l,
                                       logic o);
        t_result r;
        r.kind     = k;
        r.value    = v;
        r.len      = l;
        r.open_str = o;
        r.last     = 1'b0;
        fresh_results.push_back(r);
    endfunction

    // next state and results of the unescaper for one accepted byte
    function automatic int unescape_byte(logic [7:0] c, logic eof);
        bit line_ended;
        line_ended = 1'b0;
        case (ub_mode)
            MODE_LINE: begin
                if (c == CHAR_NL) begin
                    add_result(KIND_EOL, 8'h00, ub_len, 1'b0);
                    ub_len      = '0;
                    ub_nonempty = 1'b0;
                    line_ended  = 1'b1;
                end else begin
                    // past the limit the char is dropped, but a quote still opens
                    if (ub_len < LIMIT) begin
                        add_result(KIND_LINE, c, '0, 1'b0);
                        ub_len++;
                    end
                    if (c == CHAR_QUOTE) begin
                        if (ub_nonempty) add_result(KIND_SEP, 8'h00, '0, 1'b0);
                        ub_mode = MODE_STR;
                    end
                end
            end
            MODE_AFTER_BS: begin
                add_result(KIND_STR, c, '0, 1'b0);
                ub_nonempty = 1'b1;
                ub_mode     = MODE_STR;
            end
            default: begin
                if (ub_mode == MODE_AFTER_NL && c == CHAR_TAB) begin
                    ub_mode = MODE_STR;
                end else if (c == CHAR_QUOTE) begin
                    ub_mode = MODE_LINE;
                end else if (c == CHAR_BS) begin
                    ub_mode = MODE_AFTER_BS;
                end else begin
                    add_result(KIND_STR, c, '0, 1'b0);
                    ub_nonempty = 1'b1;
                    ub_mode     = (c == CHAR_NL) ? MODE_AFTER_NL : MODE_STR;
                end
            end
        endcase
        if (eof) begin
            // a dangling backslash is kept as a string byte
            if (ub_mode == MODE_AFTER_BS) add_result(KIND_STR, CHAR_BS, '0, 1'b0);
            if (!line_ended) add_result(KIND_EOL, 8'h00, ub_len, ub_mode != MODE_LINE);
            ub_mode     = MODE_LINE;
            ub_len      = '0;
            ub_nonempty = 1'b0;
        end
        if (fresh_results.size() > 0) fresh_results[fresh_results.size()-1].last = 1'b1;
        return fresh_results.size();
    endfunction

    // offer one byte item, hold it until taken, then book its results
    task automatic offer_byte(t_row row);
        int gap;
        if ($urandom_range(0, 39) == 0) feed_quiet = !feed_quiet;
        gap = feed_quiet ? 0 : idle_cycles();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_byte_in     <= row.data;
        i_end_of_file <= row.eof;
        do @(posedge i_clk); while (o_stall);
        fresh_results.delete();
        void'(unescape_byte(row.data, row.eof));
        if (row.typed) begin
            pending_results.push_back(
                t_result'{row.kind, row.value, row.len, row.open_str, 1'b1});
        end else begin
            foreach (fresh_results[k]) pending_results.push_back(fresh_results[k]);
        end
        n_sent++;
    endtask

    function automatic void push_byte(logic [7:0] c, logic eof);
        t_row r;
        r          = '{c, eof, 1'b0, KIND_LINE, 8'h00, '0, 1'b0};
        burst_bytes.push_back(r);
    endfunction

    // random byte that neither opens/closes a string nor ends a line
    function automatic logic [7:0] plain_char(bit in_str);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CHAR_QUOTE || c == CHAR_NL || (in_str && c == CHAR_BS));
        return c;
    endfunction

    // fill burst_bytes: 0 long line, 1 noise, otherwise a well-formed line
    function automatic void make_burst(int shape);
        int ending;
        burst_bytes.delete();
        if (shape == 0) begin
            // runs near or past the line limit; a quote past it is dropped yet opens a string
            repeat ($urandom_range(LIMIT - 4, LIMIT + 12)) push_byte(plain_char(0), 1'b0);
            if ($urandom_range(0, 1)) begin
                push_byte(CHAR_QUOTE, 1'b0);
                repeat ($urandom_range(0, 3)) push_byte(plain_char(1), 1'b0);
                push_byte(CHAR_QUOTE, 1'b0);
            end
            push_byte(CHAR_NL, 1'b0);
        end else if (shape == 1) begin
            repeat ($urandom_range(1, 8))
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            // often close the file so later lines start clean
            if ($urandom_range(0, 1)) burst_bytes[burst_bytes.size()-1].eof = 1'b1;
        end else begin
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 1)) begin
                    repeat ($urandom_range(1, 6)) push_byte(plain_char(0), 1'b0);
                end else begin
                    push_byte(CHAR_QUOTE, 1'b0);
                    repeat ($urandom_range(0, 5)) begin
                        case ($urandom_range(0, 9))
                            6, 7: begin
                                push_byte(CHAR_BS, 1'b0);
                                push_byte(8'($urandom_range(0, 255)), 1'b0);
                            end
                            8, 9: begin
                                push_byte(CHAR_NL, 1'b0);
                                if ($urandom_range(0, 1)) push_byte(CHAR_TAB, 1'b0);
                            end
                            default: push_byte(plain_char(1), 1'b0);
                        endcase
                    end
                    push_byte(CHAR_QUOTE, 1'b0);
                end
            end
            ending = $urandom_range(0, 15);
            if (ending == 0) begin
                push_byte(CHAR_NL, 1'b1);
            end else if (ending == 1) begin
                // file cut off inside a string
                push_byte(CHAR_QUOTE, 1'b0);
                push_byte(plain_char(1), 1'b1);
            end else begin
                push_byte(CHAR_NL, 1'b0);
            end
        end
    endfunction

    // byte side: reset, directed table, then random bursts
    initial begin : byte_feed
        int seq_no;
        int r;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < N_DIRECTED; i++) offer_byte(directed_rows[i]);
        seq_no = 0;
        while (n_sent < N_ITEMS) begin
            r = $urandom_range(0, 15);
            // first burst is always a long line
            make_burst(seq_no == 0 ? 0 : (r == 0 ? 0 : (r < 3 ? 1 : 2)));
            foreach (burst_bytes[k]) offer_byte(burst_bytes[k]);
            seq_no++;
        end
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // let any straggling result show up
        repeat (20) @(posedge i_clk);
        if (failures == 0) begin
            $display("** quoted_line_unescaper: PASSED **");
        end else begin
            $display("** quoted_line_unescaper: FAILED **");
        end
        $finish;
    end

    // result side: random stalls, plus one long hold-off to back up the block
    initial begin : result_drain
        int hold;
        bit held;
        held = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!held && n_checked >= 40) begin
                held    = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if ($urandom_range(0, 49) == 0) drain_quiet = !drain_quiet;
            hold = drain_quiet ? 0 : idle_cycles();
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    // every result taken is matched against the oldest one owed
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: kind %0d value %0h", o_kind, o_value);
                failures++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("value", want.value, o_value);
                check_field("line_length", want.len, o_line_length);
                check_field("open_string", want.open_str, o_open_string);
                check_field("last", want.last, o_last);
                n_checked++;
            end
        end
    end

    // watchdog
    initial begin : watchdog
        #5_000_000;
        $display("** quoted_line_unescaper: FAILED **");
        $finish;
    end

endmodule
